// ===== rtl/kfsl_pkg.sv =====
// ============================================================================
// kfsl_pkg
// Shared widths, codes and types of the keyframe segment locator.
// ============================================================================
`default_nettype none

package kfsl_pkg;

    // Field widths
    localparam int TICK_W     = 16;
    localparam int IDX_W      = 4;
    localparam int KCNT_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Command codes
    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANIM_LENGTH = 2'd0,
        CFG_LOOP_ENABLE = 2'd1,
        CFG_KEY_COUNT   = 2'd2
    } t_cfg_idx;

    // Configuration reset values
    localparam logic [TICK_W-1:0] ANIM_LENGTH_RST = 16'd0;
    localparam logic              LOOP_ENABLE_RST = 1'b1;
    localparam logic [KCNT_W-1:0] KEY_COUNT_RST   = 5'd1;

    // Saturated progress (query at the length on the wrap segment)
    localparam logic [TICK_W-1:0] PROGRESS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [TICK_W-1:0] anim_length;
        logic              loop_enable;
        logic [KCNT_W-1:0] key_count;
    } t_cfg;

    // Decoded request handed from the front to the back
    typedef struct packed {
        logic              is_query;
        logic              key_ok;
        logic [IDX_W-1:0]  key_index;
        logic [TICK_W-1:0] tick;
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/kfsl_in_if.sv =====
// ============================================================================
// kfsl_in_if
// Request channel: command, key index, key time and query time.
// ============================================================================
`default_nettype none

interface kfsl_in_if;
    import kfsl_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [IDX_W-1:0]  key_index;
    logic [TICK_W-1:0] key_time;
    logic [TICK_W-1:0] query_time;

    modport source (output valid, output command, output key_index, output key_time,
                    output query_time, input ready);
    modport sink   (input valid, input command, input key_index, input key_time,
                    input query_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/kfsl_out_if.sv =====
// ============================================================================
// kfsl_out_if
// Result channel: range flag, segment key indexes and progress.
// ============================================================================
`default_nettype none

interface kfsl_out_if;
    import kfsl_pkg::*;

    logic              valid;
    logic              ready;
    logic              in_range;
    logic [IDX_W-1:0]  prev_key;
    logic [IDX_W-1:0]  next_key;
    logic [TICK_W-1:0] progress;

    modport source (output valid, output in_range, output prev_key, output next_key,
                    output progress, input ready);
    modport sink   (input valid, input in_range, input prev_key, input next_key,
                    input progress, output ready);
endinterface

`default_nettype wire

// ===== rtl/kfsl_ram.sv =====
// ============================================================================
// kfsl_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module kfsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== rtl/kfsl_div.sv =====
// ============================================================================
// kfsl_div
// Restoring divider: Q0.16 quotient of elapsed over span, one bit a cycle.
// ============================================================================
`default_nettype none

module kfsl_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [kfsl_pkg::TICK_W-1:0] i_dividend,
    input  wire logic [kfsl_pkg::TICK_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [kfsl_pkg::TICK_W-1:0]  o_quotient
);
    import kfsl_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [TICK_W:0]      r_rem, n_rem;
    logic [TICK_W-1:0]    r_div, n_div;
    logic [TICK_W-1:0]    r_quo, n_quo;
    logic [TICK_W:0]      shifted;

    // One restoring step per cycle; dividend < divisor on entry
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_div   = r_div;
        n_quo   = r_quo;
        shifted = {r_rem[TICK_W-1:0], 1'b0};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_STEPS);
            n_rem  = {1'b0, i_dividend};
            n_div  = i_divisor;
            n_quo  = '0;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_div}) begin
                n_rem = shifted - {1'b0, r_div};
                n_quo = {r_quo[TICK_W-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[TICK_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

`default_nettype wire

// ===== rtl/kfsl_front.sv =====
// ============================================================================
// kfsl_front
// Accepts requests, decodes them and buffers them in a two-entry queue.
// ============================================================================
`default_nettype none

module kfsl_front #(
    parameter int MAX_KEYS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    kfsl_in_if.sink            i_in,
    output logic               o_op_valid,
    input  wire logic          i_op_ready,
    output kfsl_pkg::t_op      o_op
);
    import kfsl_pkg::*;

    t_op        r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_op        dec_op;
    logic       push, pop;

    // Decode: merge the tick fields, flag writes beyond the table
    always_comb begin
        dec_op.is_query  = (i_in.command == CMD_QUERY);
        dec_op.key_ok    = ({28'b0, i_in.key_index} < 32'(MAX_KEYS));
        dec_op.key_index = i_in.key_index;
        dec_op.tick      = dec_op.is_query ? i_in.query_time : i_in.key_time;
    end

    assign i_in.ready = (r_count != 2'd2);
    assign push       = i_in.valid & i_in.ready;
    assign o_op_valid = (r_count != 2'd0);
    assign pop        = o_op_valid & i_op_ready;
    assign o_op       = r_slot[r_rd_ptr];

    // Queue pointers
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= dec_op;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/kfsl_back.sv =====
// ============================================================================
// kfsl_back
// Executes requests: key table writes, segment scan, progress division.
// ============================================================================
`default_nettype none

module kfsl_back #(
    parameter int MAX_KEYS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_op_valid,
    output logic               o_op_ready,
    input  wire kfsl_pkg::t_op  i_op,
    input  wire kfsl_pkg::t_cfg i_cfg,
    kfsl_out_if.source         o_out
);
    import kfsl_pkg::*;

    localparam int KW = $clog2(MAX_KEYS);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LEN  = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_FRAC = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [TICK_W-1:0] r_len, n_len;
    logic [KW-1:0]     r_idx, n_idx;
    logic [TICK_W-1:0] r_prev_time, n_prev_time;
    logic [TICK_W-1:0] r_start, n_start;
    logic [TICK_W-1:0] r_end, n_end;
    logic [KW-1:0]     r_prev, n_prev;
    logic [KW-1:0]     r_next, n_next;
    logic              r_in_range, n_in_range;
    logic [TICK_W-1:0] r_progress, n_progress;

    logic              r_out_valid, n_out_valid;
    logic              r_out_in_range;
    logic [IDX_W-1:0]  r_out_prev, r_out_next;
    logic [TICK_W-1:0] r_out_progress;

    logic [KW-1:0]     last_idx;
    logic [KW-1:0]     ram_raddr;
    logic [TICK_W-1:0] ram_rdata;
    logic              ram_we;
    logic [TICK_W-1:0] length;
    logic              found;
    logic              div_start, div_done;
    logic [TICK_W-1:0] div_quo;
    logic              load_out;

    // Index of the last key in use, key count clamped to 1..MAX_KEYS
    always_comb begin
        if (i_cfg.key_count == '0) begin
            last_idx = '0;
        end else if ({27'b0, i_cfg.key_count} > 32'(MAX_KEYS)) begin
            last_idx = KW'(MAX_KEYS - 1);
        end else begin
            last_idx = KW'({27'b0, i_cfg.key_count} - 32'd1);
        end
    end

    // Key table
    kfsl_ram #(
        .WIDTH (TICK_W),
        .DEPTH (MAX_KEYS)
    ) u_kfsl_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (KW'(i_op.key_index)),
        .i_wdata (i_op.tick),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Progress divider
    kfsl_div u_kfsl_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tick - r_start),
        .i_divisor  (r_end - r_start),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_op_ready = (r_state == ST_IDLE);
    assign ram_we     = (r_state == ST_IDLE) && i_op_valid && !i_op.is_query && i_op.key_ok;
    assign length     = i_cfg.loop_enable ? i_cfg.anim_length : ram_rdata;
    assign found      = (r_idx != '0) && (ram_rdata > r_tick);
    assign load_out   = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    // Read address: last key first (length), then keys 0, 1, 2, ...
    always_comb begin
        case (r_state)
            ST_IDLE: ram_raddr = last_idx;
            ST_SCAN: ram_raddr = r_idx + KW'(1);
            default: ram_raddr = '0;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_len       = r_len;
        n_idx       = r_idx;
        n_prev_time = r_prev_time;
        n_start     = r_start;
        n_end       = r_end;
        n_prev      = r_prev;
        n_next      = r_next;
        n_in_range  = r_in_range;
        n_progress  = r_progress;
        div_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_op_valid) begin
                    n_tick     = i_op.tick;
                    n_in_range = 1'b0;
                    n_prev     = '0;
                    n_next     = '0;
                    n_progress = '0;
                    n_state    = i_op.is_query ? ST_LEN : ST_EMIT;
                end
            end
            ST_LEN: begin
                // Data holds the last key time
                if (r_tick > length) begin
                    n_state = ST_EMIT;
                end else begin
                    n_len   = length;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Data holds key r_idx
                if (found) begin
                    n_prev  = r_idx - KW'(1);
                    n_next  = r_idx;
                    n_start = r_prev_time;
                    n_end   = ram_rdata;
                    n_state = ST_FRAC;
                end else if (r_idx == last_idx) begin
                    // wrap segment: last key to the length
                    n_prev  = last_idx;
                    n_next  = '0;
                    n_start = ram_rdata;
                    n_end   = r_len;
                    n_state = ST_FRAC;
                end else begin
                    n_prev_time = ram_rdata;
                    n_idx       = r_idx + KW'(1);
                end
            end
            ST_FRAC: begin
                n_in_range = 1'b1;
                if (r_end <= r_start || r_tick < r_start) begin
                    n_progress = '0;
                    n_state    = ST_EMIT;
                end else if (r_tick == r_end) begin
                    n_progress = PROGRESS_MAX;
                    n_state    = ST_EMIT;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_progress = div_quo;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_tick      <= n_tick;
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_prev_time <= n_prev_time;
        r_start     <= n_start;
        r_end       <= n_end;
        r_prev      <= n_prev;
        r_next      <= n_next;
        r_in_range  <= n_in_range;
        r_progress  <= n_progress;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_in_range <= r_in_range;
            r_out_prev     <= IDX_W'(r_prev);
            r_out_next     <= IDX_W'(r_next);
            r_out_progress <= r_progress;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.in_range = r_out_in_range;
    assign o_out.prev_key = r_out_prev;
    assign o_out.next_key = r_out_next;
    assign o_out.progress = r_out_progress;
endmodule

`default_nettype wire

// ===== rtl/keyframe_segment_locator.sv =====
// ============================================================================
// keyframe_segment_locator
// Keyframe table with segment lookup and Q0.16 progress for animation time.
// ============================================================================
// Usage:
//   i_in carries requests: a write stores key_time at key_index, a query
//   locates query_time. o_out carries one result per request: in_range,
//   prev_key, next_key and progress (all zero for writes and for times past
//   the animation length). i_cfg_we/i_cfg_idx/i_cfg_data write anim_length,
//   loop_enable and key_count; write them only while no request is pending.
// Execution:
//   A write passes through the back end states IDLE and EMIT. A query reads
//   the last key time, then scans up to the index where the scan stops (the
//   first later key, or the last key in use), one key table read per cycle
//   during the scan, then runs the bit-serial divider where a quotient is
//   needed. Requests are taken one at a time. A two-entry request queue ahead
//   of the back end accepts new requests while a query is in work or a result waits.
// Reset:
//   Synchronous, active low. Clears the queue, the result register and the
//   sequencer; config returns to length 0, looping on, one key. The key
//   table is not cleared: query only keys that were written.
// Stall:
//   A result holds in the output register until taken; the back end then
//   stalls and the queue fills, after which i_in.ready drops.
// ============================================================================
`default_nettype none

module keyframe_segment_locator #(
    parameter int MAX_KEYS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    kfsl_in_if.sink                             i_in,
    kfsl_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [kfsl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [kfsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kfsl_pkg::*;

    t_cfg r_cfg;
    t_op  op;
    logic op_valid, op_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.anim_length <= ANIM_LENGTH_RST;
            r_cfg.loop_enable <= LOOP_ENABLE_RST;
            r_cfg.key_count   <= KEY_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ANIM_LENGTH: r_cfg.anim_length <= i_cfg_data;
                CFG_LOOP_ENABLE: r_cfg.loop_enable <= i_cfg_data[0];
                CFG_KEY_COUNT:   r_cfg.key_count   <= i_cfg_data[KCNT_W-1:0];
                default: ;
            endcase
        end
    end

    kfsl_front #(
        .MAX_KEYS (MAX_KEYS)
    ) u_kfsl_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    kfsl_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_kfsl_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .o_op_ready (op_ready),
        .i_op       (op),
        .i_cfg      (r_cfg),
        .o_out      (o_out)
    );
endmodule

`default_nettype wire

// ===== rtl/kfsl_checker.sv =====
// ============================================================================
// kfsl_checker
// Port-level checks on the result channel of the segment locator.
// ============================================================================
`default_nettype none

module kfsl_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic                         i_in_range,
    input  wire logic [kfsl_pkg::IDX_W-1:0]  i_prev_key,
    input  wire logic [kfsl_pkg::IDX_W-1:0]  i_next_key,
    input  wire logic [kfsl_pkg::TICK_W-1:0] i_progress
);
    import kfsl_pkg::*;

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Out-of-range and write results carry all-zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_in_range |->
            (i_prev_key == '0) && (i_next_key == '0) && (i_progress == '0))
        else $error("nonzero fields on out-of-range result");

    // A regular segment starts at the key just before its end key
    a_adjacent_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_in_range && (i_next_key != '0) |->
            (i_prev_key == IDX_W'(i_next_key - IDX_W'(1))))
        else $error("segment keys not adjacent");
endmodule

bind keyframe_segment_locator kfsl_checker u_kfsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_in_range  (o_out.in_range),
    .i_prev_key  (o_out.prev_key),
    .i_next_key  (o_out.next_key),
    .i_progress  (o_out.progress)
);

`default_nettype wire
